@@ design/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

   // frame buffer size, sets the length and request limits
   localparam int BUFFER_LEN = 256;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int ELAPSED_W  = 17;
   localparam int LIMIT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0]   BUFFER_LEN_C      = COUNT_W'(BUFFER_LEN);
   localparam logic [BYTE_W-1:0]    MIN_TRIGGER_COUNT = 8'd3;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX       = {ELAPSED_W{1'b1}};

   // register reset values
   localparam logic [BYTE_W-1:0]  LENGTH_POSITION_RST = 8'd255;
   localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST   = 16'd100;

   typedef enum logic [1:0] {
      ACT_ARM  = 2'd0,
      ACT_BYTE = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BUSY        = 2'd1,
      ST_TOO_LONG    = 2'd2,
      ST_BAD_TRIGGER = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_WAIT = 3'd1,
      PH_RX   = 3'd2,
      PH_DONE = 3'd3,
      PH_ERR  = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_CHAR      = 3'd0,
      REG_STOP_CHAR       = 3'd1,
      REG_REQUEST_COUNT   = 3'd2,
      REG_LENGTH_POSITION = 3'd3,
      REG_LENGTH_ADJUST   = 3'd4,
      REG_TIMEOUT_LIMIT   = 3'd5,
      REG_TIMEOUT_ENABLES = 3'd6,
      REG_UNUSED          = 3'd7
   } reg_index_type;

   // configuration seen by the framer core
   typedef struct packed {
      logic [BYTE_W-1:0]  start_char;
      logic [BYTE_W-1:0]  stop_char;
      logic [BYTE_W-1:0]  request_count;
      logic [BYTE_W-1:0]  length_position;
      logic [BYTE_W-1:0]  length_adjust;
      logic [LIMIT_W-1:0] timeout_limit;
      logic [1:0]         timeout_enables;
   } cfg_type;

   typedef struct packed {
      action_type        action;
      logic [BYTE_W-1:0] rx_byte;
      logic              overrun;
   } item_type;

   typedef struct packed {
      status_type         arm_status;
      phase_type          rx_phase_out;
      logic               store_valid;
      logic [BYTE_W-1:0]  store_index;
      logic [BYTE_W-1:0]  store_byte;
      logic [COUNT_W-1:0] received_count;
   } result_type;

endpackage

@@ design/sfr_if.sv @@
`timescale 1ns / 1ps

// input word channel
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] rx_byte;
   logic       overrun;

   modport source (output valid, action, rx_byte, overrun, input ready);
   modport sink (input valid, action, rx_byte, overrun, output ready);
endinterface

// result word channel
interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] arm_status;
   logic [2:0] rx_phase_out;
   logic       store_valid;
   logic [7:0] store_index;
   logic [7:0] store_byte;
   logic [8:0] received_count;

   modport source (output valid, arm_status, rx_phase_out, store_valid, store_index,
                   store_byte, received_count, input ready);
   modport sink (input valid, arm_status, rx_phase_out, store_valid, store_index,
                 store_byte, received_count, output ready);
endinterface

// register write channel
interface sfr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/serial_frame_receiver.sv @@
`timescale 1ns / 1ps

// serial frame receiver
// req_if carries one word per serial event: arm, received byte or time tick.
// rsp_if returns exactly one result word per request word, in order: the arm
// status, the phase after the event, an optional buffer store (index, byte)
// and the running byte count of the frame.
// csr_if writes the framing registers (start/stop chars, request count,
// length position and adjust, timeout limit and enables); always ready,
// effective on the next word. Write it only while no word is in flight.
// A word accepted into the input register passes through the framing logic
// into the result register, which drives rsp valid.
// Throughput: one word per cycle while rsp_if takes results; a single input
// register feeds one pass of framing logic into the result register.
// A stalled rsp_if holds the result; the input register still takes a word,
// and req_if ready drops only while both registers are full.
// Reset clears the registers to their defaults, the framer to idle and both
// channels to empty.

module serial_frame_receiver (
   input logic        clock,
   input logic        reset,
   sfr_req_if.sink    req_if,
   sfr_rsp_if.source  rsp_if,
   sfr_csr_if.sink    csr_if
);

   sfr_pkg::cfg_type cfg;

   sfr_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   sfr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

@@ design/sfr_csr.sv @@
`timescale 1ns / 1ps

module sfr_csr (
   input  logic             clock,
   input  logic             reset,
   sfr_csr_if.sink          csr_if,
   output sfr_pkg::cfg_type cfg
);

   sfr_pkg::cfg_type cfg_ff;
   logic             wr_en;

   // writes are always taken
   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;
   assign cfg          = cfg_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_char      <= '0;
         cfg_ff.stop_char       <= '0;
         cfg_ff.request_count   <= '0;
         cfg_ff.length_position <= sfr_pkg::LENGTH_POSITION_RST;
         cfg_ff.length_adjust   <= '0;
         cfg_ff.timeout_limit   <= sfr_pkg::TIMEOUT_LIMIT_RST;
         cfg_ff.timeout_enables <= '0;
      end else if (wr_en) begin
         case (sfr_pkg::reg_index_type'(csr_if.index))
            sfr_pkg::REG_START_CHAR:      cfg_ff.start_char      <= csr_if.data[7:0];
            sfr_pkg::REG_STOP_CHAR:       cfg_ff.stop_char       <= csr_if.data[7:0];
            sfr_pkg::REG_REQUEST_COUNT:   cfg_ff.request_count   <= csr_if.data[7:0];
            sfr_pkg::REG_LENGTH_POSITION: cfg_ff.length_position <= csr_if.data[7:0];
            sfr_pkg::REG_LENGTH_ADJUST:   cfg_ff.length_adjust   <= csr_if.data[7:0];
            sfr_pkg::REG_TIMEOUT_LIMIT:   cfg_ff.timeout_limit   <= csr_if.data[15:0];
            sfr_pkg::REG_TIMEOUT_ENABLES: cfg_ff.timeout_enables <= csr_if.data[1:0];
            default: ;
         endcase
      end
   end

endmodule

@@ design/sfr_core.sv @@
`timescale 1ns / 1ps

module sfr_core (
   input  logic             clock,
   input  logic             reset,
   input  sfr_pkg::cfg_type cfg,
   sfr_req_if.sink          req_if,
   sfr_rsp_if.source        rsp_if
);

   // input register
   logic              in_valid_ff;
   sfr_pkg::item_type item_ff;
   logic              advance;

   // frame state
   sfr_pkg::phase_type              phase_ff, phase_in;
   logic [sfr_pkg::COUNT_W-1:0]     byte_count_ff, byte_count_in;
   logic [sfr_pkg::COUNT_W-1:0]     target_ff, target_in;
   logic [sfr_pkg::BYTE_W-1:0]      last_stored_ff, last_stored_in;
   logic                            rx_running_ff, rx_running_in;
   logic [sfr_pkg::ELAPSED_W-1:0]   rx_elapsed_ff, rx_elapsed_in;
   logic [sfr_pkg::ELAPSED_W-1:0]   wait_elapsed_ff, wait_elapsed_in;

   // result register
   logic                            rsp_valid_ff;
   sfr_pkg::result_type             res_ff, res_in;

   // byte handling helpers
   logic [sfr_pkg::COUNT_W-1:0]     len_sum;
   logic [sfr_pkg::COUNT_W-1:0]     limit_ext;
   logic                            rx_err;
   logic                            rx_end;

   // the item moves on when the result register is free or being drained
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   assign len_sum   = {1'b0, item_ff.rx_byte} + {1'b0, cfg.length_adjust};
   assign limit_ext = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         item_ff.action  <= sfr_pkg::action_type'(req_if.action);
         item_ff.rx_byte <= req_if.rx_byte;
         item_ff.overrun <= req_if.overrun;
      end
   end

   // next state and result for the word in the input register
   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      target_in       = target_ff;
      last_stored_in  = last_stored_ff;
      rx_running_in   = rx_running_ff;
      rx_elapsed_in   = rx_elapsed_ff;
      wait_elapsed_in = wait_elapsed_ff;
      rx_err          = 1'b0;
      rx_end          = 1'b0;
      res_in          = '0;
      res_in.arm_status = sfr_pkg::ST_OK;

      case (item_ff.action)
         sfr_pkg::ACT_ARM: begin
            if (phase_ff == sfr_pkg::PH_RX) begin
               res_in.arm_status = sfr_pkg::ST_BUSY;
            end else if ({1'b0, cfg.request_count} >= sfr_pkg::BUFFER_LEN_C) begin
               res_in.arm_status = sfr_pkg::ST_TOO_LONG;
            end else if ((cfg.start_char != '0 || cfg.stop_char != '0) &&
                         cfg.request_count < sfr_pkg::MIN_TRIGGER_COUNT) begin
               res_in.arm_status = sfr_pkg::ST_BAD_TRIGGER;
            end else begin
               phase_in        = (cfg.start_char != '0) ? sfr_pkg::PH_WAIT : sfr_pkg::PH_RX;
               byte_count_in   = '0;
               target_in       = {1'b0, cfg.request_count};
               rx_running_in   = 1'b0;
               rx_elapsed_in   = '0;
               wait_elapsed_in = '0;
            end
         end
         sfr_pkg::ACT_BYTE: begin
            if (!item_ff.overrun) begin
               if (phase_ff == sfr_pkg::PH_RX) begin
                  rx_running_in = 1'b1;
                  rx_elapsed_in = '0;
                  if (byte_count_ff < target_ff) begin
                     res_in.store_valid = 1'b1;
                     res_in.store_index = byte_count_ff[sfr_pkg::BYTE_W-1:0];
                     res_in.store_byte  = item_ff.rx_byte;
                     last_stored_in     = item_ff.rx_byte;
                     // length field overrides the target count
                     if ({1'b0, cfg.length_position} == byte_count_ff) begin
                        if (len_sum >= sfr_pkg::BUFFER_LEN_C) begin
                           rx_err = 1'b1;
                        end else begin
                           target_in = len_sum;
                        end
                     end
                     byte_count_in = byte_count_ff + 1'b1;
                  end
                  if (cfg.stop_char != '0 && byte_count_in != '0 &&
                      last_stored_in == cfg.stop_char) begin
                     rx_end = 1'b1;
                  end
                  if (byte_count_in >= target_in) begin
                     rx_end = 1'b1;
                  end
                  if (rx_err) begin
                     phase_in      = sfr_pkg::PH_ERR;
                     rx_running_in = 1'b0;
                  end else if (rx_end) begin
                     phase_in      = sfr_pkg::PH_DONE;
                     rx_running_in = 1'b0;
                  end
               end else if (phase_ff == sfr_pkg::PH_WAIT) begin
                  if (item_ff.rx_byte == cfg.start_char) begin
                     res_in.store_valid = 1'b1;
                     res_in.store_index = byte_count_ff[sfr_pkg::BYTE_W-1:0];
                     res_in.store_byte  = item_ff.rx_byte;
                     last_stored_in     = item_ff.rx_byte;
                     byte_count_in      = byte_count_ff + 1'b1;
                     phase_in           = sfr_pkg::PH_RX;
                  end
               end
            end
         end
         sfr_pkg::ACT_TICK: begin
            if (phase_ff == sfr_pkg::PH_RX && rx_running_ff) begin
               if (rx_elapsed_ff != sfr_pkg::ELAPSED_MAX) begin
                  rx_elapsed_in = rx_elapsed_ff + 1'b1;
               end
               if (cfg.timeout_enables[0] && rx_elapsed_in > {1'b0, cfg.timeout_limit}) begin
                  phase_in      = sfr_pkg::PH_ERR;
                  rx_running_in = 1'b0;
               end
            end else if (phase_ff == sfr_pkg::PH_WAIT) begin
               if (wait_elapsed_ff != sfr_pkg::ELAPSED_MAX) begin
                  wait_elapsed_in = wait_elapsed_ff + 1'b1;
               end
               if (cfg.timeout_enables[1] &&
                   wait_elapsed_in > {1'b0, cfg.timeout_limit}) begin
                  phase_in = sfr_pkg::PH_ERR;
               end
            end
         end
         default: ;
      endcase

      res_in.rx_phase_out   = phase_in;
      res_in.received_count = byte_count_in | limit_ext;
   end

   // frame state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sfr_pkg::PH_IDLE;
         byte_count_ff   <= '0;
         target_ff       <= '0;
         last_stored_ff  <= '0;
         rx_running_ff   <= 1'b0;
         rx_elapsed_ff   <= '0;
         wait_elapsed_ff <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         target_ff       <= target_in;
         last_stored_ff  <= last_stored_in;
         rx_running_ff   <= rx_running_in;
         rx_elapsed_ff   <= rx_elapsed_in;
         wait_elapsed_ff <= wait_elapsed_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.arm_status     = res_ff.arm_status;
   assign rsp_if.rx_phase_out   = res_ff.rx_phase_out;
   assign rsp_if.store_valid    = res_ff.store_valid;
   assign rsp_if.store_index    = res_ff.store_index;
   assign rsp_if.store_byte     = res_ff.store_byte;
   assign rsp_if.received_count = res_ff.received_count;

   // the receive timer only runs inside a frame
   a_timer_in_rx: assert property (@(posedge clock) disable iff (reset)
      rx_running_ff |-> phase_ff == sfr_pkg::PH_RX)
      else $error("receive timer running outside receiving phase");

   // byte count never passes the buffer size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= sfr_pkg::BUFFER_LEN_C)
      else $error("byte count beyond buffer size");

   // an arm while receiving leaves the frame alone
   a_busy_keeps: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.action == sfr_pkg::ACT_ARM && phase_ff == sfr_pkg::PH_RX)
      |=> (phase_ff == sfr_pkg::PH_RX && $stable(byte_count_ff) && $stable(target_ff)))
      else $error("busy arm changed frame state");

   // a stored byte always bumps the count by one
   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && res_in.store_valid) |=> byte_count_ff == $past(byte_count_ff) + 1'b1)
      else $error("stored byte did not advance the count");

   // every item that moves on produces a result word
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result word lost");

endmodule
